>>> rtl/tla_pkg.sv
// ----------------------------------------------------------------------------
// Threshold level alarm package
// Shared widths, level indices and register map of the level alarm core.
// ----------------------------------------------------------------------------
`default_nettype none

package tla_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int TIME_WIDTH  = 32;
    localparam int DELAY_WIDTH = 31;
    localparam int NUM_LEVELS  = 4;
    localparam int ADDR_WIDTH  = 5;
    localparam int DATA_WIDTH  = 32;

    localparam int LVL_HIGH_HIGH = 0;
    localparam int LVL_HIGH      = 1;
    localparam int LVL_LOW       = 2;
    localparam int LVL_LOW_LOW   = 3;

    // Levels that trip above their setpoint.
    localparam logic [NUM_LEVELS-1:0] HIGH_LEVELS =
        NUM_LEVELS'((1 << LVL_HIGH_HIGH) | (1 << LVL_HIGH));

    localparam logic [2:0] REG_HIGH_HIGH_SP = 3'd0;
    localparam logic [2:0] REG_HIGH_SP      = 3'd1;
    localparam logic [2:0] REG_LOW_SP       = 3'd2;
    localparam logic [2:0] REG_LOW_LOW_SP   = 3'd3;
    localparam logic [2:0] REG_DEADBAND     = 3'd4;
    localparam logic [2:0] REG_ON_DELAY     = 3'd5;
    localparam logic [2:0] REG_OFF_DELAY    = 3'd6;
    localparam logic [2:0] REG_LEVEL_ENABLE = 3'd7;

    // Signed difference of value and setpoint, wide enough to compare
    // against the deadband without overflow.
    localparam int DIFF_WIDTH = ((VALUE_WIDTH > DELAY_WIDTH) ? VALUE_WIDTH : DELAY_WIDTH) + 2;
    localparam int CMP_WIDTH  = (TIME_WIDTH > DELAY_WIDTH) ? TIME_WIDTH : DELAY_WIDTH;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic        [TIME_WIDTH-1:0]  stamp_t;
    typedef logic        [DELAY_WIDTH-1:0] delay_t;
    typedef logic        [NUM_LEVELS-1:0]  level_mask_t;

endpackage

`default_nettype wire

>>> rtl/threshold_level_alarm_core.sv
// ----------------------------------------------------------------------------
// Threshold level alarm core
// Four-level process alarm (high-high, high, low, low-low) with a shared
// deadband and on/off delays, evaluated once per timestamped sample.
// ----------------------------------------------------------------------------
`default_nettype none

// Each sample beat is captured in an input register and evaluated there;
// the four level checks and the alarm state update happen together as the
// result is loaded into the output register. A new sample beat can be
// taken every cycle while the consumer keeps up, so the sustained rate is
// one beat per cycle; the output register holds a result while the
// consumer stalls and the input register keeps taking beats until both are
// full. Configuration is to be written through the APB port only while the
// core is idle; the core itself does not enforce this.
module threshold_level_alarm_core (
    input  wire                                    aclk,
    input  wire                                    aresetn,

    input  wire                                    psel,
    input  wire                                    penable,
    input  wire                                    pwrite,
    input  wire  [tla_pkg::ADDR_WIDTH-1:0]         paddr,
    input  wire  [tla_pkg::DATA_WIDTH-1:0]         pwdata,
    output logic [tla_pkg::DATA_WIDTH-1:0]         prdata,
    output logic                                   pready,

    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  wire  signed [tla_pkg::VALUE_WIDTH-1:0] s_sample_value,
    input  wire  [tla_pkg::TIME_WIDTH-1:0]         s_sample_time,
    input  wire                                    s_quality_bad,

    output logic                                   m_valid,
    input  wire                                    m_ready,
    output logic [tla_pkg::NUM_LEVELS-1:0]         m_raised_mask,
    output logic [tla_pkg::NUM_LEVELS-1:0]         m_cleared_mask,
    output logic [tla_pkg::NUM_LEVELS-1:0]         m_active_mask
);

    import tla_pkg::*;

    value_t      setpoint_reg [NUM_LEVELS];
    delay_t      deadband_reg;
    delay_t      on_delay_reg;
    delay_t      off_delay_reg;
    level_mask_t enable_reg;

    logic        cfg_write;
    logic [2:0]  cfg_index;

    logic        in_valid_reg;
    value_t      in_value_reg;
    stamp_t      in_time_reg;
    logic        in_bad_reg;

    logic        out_valid_reg;
    level_mask_t raised_reg;
    level_mask_t cleared_reg;
    level_mask_t active_out_reg;

    level_mask_t active_reg;
    level_mask_t active_next;
    level_mask_t pending_reg;
    level_mask_t pending_next;
    stamp_t      start_reg [NUM_LEVELS];
    stamp_t      start_next [NUM_LEVELS];
    level_mask_t raised_next;
    level_mask_t cleared_next;

    logic        advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                setpoint_reg[i] <= '0;
            end
            deadband_reg  <= '0;
            on_delay_reg  <= '0;
            off_delay_reg <= '0;
            enable_reg    <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_HIGH_HIGH_SP: setpoint_reg[LVL_HIGH_HIGH] <= pwdata[VALUE_WIDTH-1:0];
                REG_HIGH_SP:      setpoint_reg[LVL_HIGH]      <= pwdata[VALUE_WIDTH-1:0];
                REG_LOW_SP:       setpoint_reg[LVL_LOW]       <= pwdata[VALUE_WIDTH-1:0];
                REG_LOW_LOW_SP:   setpoint_reg[LVL_LOW_LOW]   <= pwdata[VALUE_WIDTH-1:0];
                REG_DEADBAND:     deadband_reg                <= pwdata[DELAY_WIDTH-1:0];
                REG_ON_DELAY:     on_delay_reg                <= pwdata[DELAY_WIDTH-1:0];
                REG_OFF_DELAY:    off_delay_reg               <= pwdata[DELAY_WIDTH-1:0];
                REG_LEVEL_ENABLE: enable_reg                  <= pwdata[NUM_LEVELS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_index)
            REG_HIGH_HIGH_SP: prdata = DATA_WIDTH'(setpoint_reg[LVL_HIGH_HIGH]);
            REG_HIGH_SP:      prdata = DATA_WIDTH'(setpoint_reg[LVL_HIGH]);
            REG_LOW_SP:       prdata = DATA_WIDTH'(setpoint_reg[LVL_LOW]);
            REG_LOW_LOW_SP:   prdata = DATA_WIDTH'(setpoint_reg[LVL_LOW_LOW]);
            REG_DEADBAND:     prdata = DATA_WIDTH'(deadband_reg);
            REG_ON_DELAY:     prdata = DATA_WIDTH'(on_delay_reg);
            REG_OFF_DELAY:    prdata = DATA_WIDTH'(off_delay_reg);
            REG_LEVEL_ENABLE: prdata = DATA_WIDTH'(enable_reg);
            default:          prdata = '0;
        endcase
    end

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_value_reg <= s_sample_value;
            in_time_reg  <= s_sample_time;
            in_bad_reg   <= s_quality_bad;
        end
    end

    always_comb begin
        logic signed [DIFF_WIDTH-1:0] val_ext;
        logic signed [DIFF_WIDTH-1:0] sp_ext;
        logic signed [DIFF_WIDTH-1:0] band_ext;
        logic signed [DIFF_WIDTH-1:0] diff;
        logic        [CMP_WIDTH-1:0]  elapsed;
        logic        [CMP_WIDTH-1:0]  delay;
        logic                         cond;
        active_next  = active_reg;
        pending_next = pending_reg;
        raised_next  = '0;
        cleared_next = '0;
        val_ext      = DIFF_WIDTH'(in_value_reg);
        band_ext     = $signed({{(DIFF_WIDTH-DELAY_WIDTH){1'b0}}, deadband_reg});
        for (int i = 0; i < NUM_LEVELS; i++) begin
            start_next[i] = start_reg[i];
            sp_ext        = DIFF_WIDTH'(setpoint_reg[i]);
            diff          = HIGH_LEVELS[i] ? (sp_ext - val_ext) : (val_ext - sp_ext);
            cond          = active_reg[i] ? (diff > band_ext) : (diff < 0);
            elapsed       = pending_reg[i] ? CMP_WIDTH'(in_time_reg - start_reg[i]) : '0;
            delay         = active_reg[i] ? CMP_WIDTH'(off_delay_reg)
                                          : CMP_WIDTH'(on_delay_reg);
            if (!in_bad_reg && enable_reg[i]) begin
                if (!cond) begin
                    pending_next[i] = 1'b0;
                    start_next[i]   = '0;
                end else if (elapsed >= delay) begin
                    raised_next[i]  = !active_reg[i];
                    cleared_next[i] = active_reg[i];
                    active_next[i]  = !active_reg[i];
                    pending_next[i] = 1'b0;
                    start_next[i]   = '0;
                end else if (!pending_reg[i]) begin
                    pending_next[i] = 1'b1;
                    start_next[i]   = in_time_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= '0;
            pending_reg <= '0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                start_reg[i] <= '0;
            end
        end else if (advance) begin
            active_reg  <= active_next;
            pending_reg <= pending_next;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                start_reg[i] <= start_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            raised_reg     <= raised_next;
            cleared_reg    <= cleared_next;
            active_out_reg <= active_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_raised_mask  = raised_reg;
    assign m_cleared_mask = cleared_reg;
    assign m_active_mask  = active_out_reg;

`ifndef SYNTHESIS
    a_raise_clear_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((raised_reg & cleared_reg) == '0))
        else $error("A level both raised and cleared on one beat.");

    a_raised_is_active: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((raised_reg & ~active_out_reg) == '0))
        else $error("A raised level is missing from the active mask.");

    a_cleared_not_active: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((cleared_reg & active_out_reg) == '0))
        else $error("A cleared level still shows as active.");

    a_idle_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !pending_reg[LVL_HIGH_HIGH] |-> (start_reg[LVL_HIGH_HIGH] == '0))
        else $error("High-high start time is set while the level is not pending.");

    a_state_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(active_reg) && $stable(pending_reg))
        else $error("Alarm state changed without a beat being evaluated.");
`endif

endmodule

`default_nettype wire
